// ===== hw/rtl/spi_pkg.sv =====
// Shared types and constants for the segment pair intersection core.
// No dependencies; every other file imports this package.
package spi_pkg;

    localparam int CW  = 32;            // coordinate width
    localparam int DW  = CW + 1;        // coordinate difference width
    localparam int XW  = 2 * DW + 1;    // cross product width
    localparam int TW  = 16;            // tolerance width
    localparam int LSW = 34;            // low slice of the cross product for the point multiply
    localparam int PW  = DW + XW;       // point numerator product width
    localparam int QW  = 37;            // quotient bits produced by the divider
    localparam int KSH = 35;            // quotient bias, makes the dividend non-negative
    localparam int RW  = XW + 1;        // divisor (twice the denominator) and remainder width
    localparam int NW  = QW + RW;       // dividend width
    localparam int SW  = QW + 2;        // biased sum width
    localparam int FIFO_DEPTH = 4;
    localparam int FAW = 2;

    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic [TW-1:0] TOL_RESET = 16'd66;

    typedef enum logic [1:0] {
        HOW_NONE     = 2'd0,
        HOW_SHARED   = 2'd1,
        HOW_CROSS    = 2'd2,
        HOW_PARALLEL = 2'd3
    } how_t;

    typedef struct packed {
        logic                 shared;
        logic signed [CW-1:0] sh_px;
        logic signed [CW-1:0] sh_py;
        logic signed [CW-1:0] asx;
        logic signed [CW-1:0] asy;
        logic signed [DW-1:0] v1x;
        logic signed [DW-1:0] v1y;
        logic signed [DW-1:0] v2x;
        logic signed [DW-1:0] v2y;
        logic signed [DW-1:0] v3x;
        logic signed [DW-1:0] v3y;
    } item_t;

    typedef struct packed {
        logic                 shared;
        logic                 par;
        logic                 in_rng;
        logic signed [CW-1:0] sh_px;
        logic signed [CW-1:0] sh_py;
        logic signed [CW-1:0] asx;
        logic signed [CW-1:0] asy;
    } side_t;

endpackage

// ===== hw/rtl/spi_front.sv =====
// Front end: forms the segment direction vectors and spots a shared endpoint.
// Depends on spi_pkg.
module spi_front import spi_pkg::*; (
    input  logic signed [CW-1:0] a_start_x,
    input  logic signed [CW-1:0] a_start_y,
    input  logic signed [CW-1:0] a_end_x,
    input  logic signed [CW-1:0] a_end_y,
    input  logic signed [CW-1:0] b_start_x,
    input  logic signed [CW-1:0] b_start_y,
    input  logic signed [CW-1:0] b_end_x,
    input  logic signed [CW-1:0] b_end_y,
    output item_t                item
);

    logic as_bs, as_be, ae_bs, ae_be, start_shared, end_shared;

    assign as_bs = (a_start_x == b_start_x) && (a_start_y == b_start_y);
    assign as_be = (a_start_x == b_end_x)   && (a_start_y == b_end_y);
    assign ae_bs = (a_end_x == b_start_x)   && (a_end_y == b_start_y);
    assign ae_be = (a_end_x == b_end_x)     && (a_end_y == b_end_y);

    assign start_shared = (as_bs && !ae_be) || (as_be && !ae_bs);
    assign end_shared   = (ae_bs && !as_be) || (ae_be && !as_bs);

    always_comb begin
        item.shared = start_shared || end_shared;
        item.sh_px  = start_shared ? a_start_x : a_end_x;
        item.sh_py  = start_shared ? a_start_y : a_end_y;
        item.asx    = a_start_x;
        item.asy    = a_start_y;
        item.v1x    = DW'(a_end_x) - DW'(a_start_x);
        item.v1y    = DW'(a_end_y) - DW'(a_start_y);
        item.v2x    = DW'(b_end_x) - DW'(b_start_x);
        item.v2y    = DW'(b_end_y) - DW'(b_start_y);
        item.v3x    = DW'(b_start_x) - DW'(a_start_x);
        item.v3y    = DW'(b_start_y) - DW'(a_start_y);
    end

endmodule

// ===== hw/rtl/spi_fifo.sv =====
// Short request queue between the front end and the arithmetic back end.
// Depends on spi_pkg.
module spi_fifo import spi_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    item_t          mem_reg [FIFO_DEPTH];
    logic [FAW-1:0] wp_reg, rp_reg;
    logic [FAW:0]   cnt_reg;
    logic           push, pop;

    assign wr_ready = (cnt_reg != (FAW+1)'(FIFO_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wr_item;
    end

endmodule

// ===== hw/rtl/spi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on spi_pkg.
module spi_div import spi_pkg::*; (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [RW-1:0] den,
    output logic [QW-1:0] quot
);

    logic [RW-1:0] rem_reg [QW+1];
    logic [QW-1:0] low_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic [RW-1:0] den_reg [QW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num[NW-1:QW];
            low_reg[0] <= num[QW-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [RW-1:0] t;
        logic          ge;
        assign t  = {rem_reg[s][RW-2:0], low_reg[s][QW-1]};
        assign ge = (t >= den_reg[s]);
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1] <= ge ? (t - den_reg[s]) : t;
                low_reg[s+1] <= {low_reg[s][QW-2:0], 1'b0};
                q_reg[s+1]   <= {q_reg[s][QW-2:0], ge};
                den_reg[s+1] <= den_reg[s];
            end
        end
    end

    assign quot = q_reg[QW];

endmodule

// ===== hw/rtl/spi_back.sv =====
// Back end: cross products, parallel and range tests, point division, result register.
// Depends on spi_pkg and spi_div.
module spi_back import spi_pkg::*; #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [TW-1:0]        tolerance,
    input  logic                 in_valid,
    input  item_t                in_item,
    output logic                 in_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output how_t                 m_how,
    output logic signed [CW-1:0] m_px,
    output logic signed [CW-1:0] m_py
);

    localparam int PSH = 2 * COORD_FRAC_BITS - TW;
    localparam int DL  = QW + 1;   // divider latency

    logic adv;
    assign adv      = !m_valid || m_ready;
    assign in_ready = adv;

    // Stage 1: products
    logic                   v1_reg;
    logic signed [2*DW-1:0] pd1_reg, pd2_reg, pc1a_reg, pc1b_reg, pc2a_reg, pc2b_reg;
    side_t                  sd1_reg;
    logic signed [DW-1:0]   vx1_reg, vy1_reg;

    // Stage 2: cross products
    logic                 v2_reg;
    logic signed [XW-1:0] d2s_reg, c12_reg, c22_reg;
    side_t                sd2_reg;
    logic signed [DW-1:0] vx2_reg, vy2_reg;

    // Stage 3: positive denominator
    logic                 v3_reg;
    logic [XW-1:0]        d3_reg;
    logic signed [XW-1:0] c13_reg, c23_reg;
    side_t                sd3_reg;
    logic signed [DW-1:0] vx3_reg, vy3_reg;

    // Stage 4
    logic                       v4_reg;
    logic [TW+XW-1:0]           td_reg;
    logic [XW-1:0]              d4_reg;
    logic signed [XW-1:0]       c14_reg, c24_reg;
    logic signed [DW+LSW:0]     pxl_reg, pyl_reg;
    logic signed [DW+XW-LSW-1:0] pxh_reg, pyh_reg;
    side_t                      sd4_reg, sd4_next;

    // Stage 5
    logic                 v5_reg;
    logic signed [PW-1:0] px5_reg, py5_reg;
    logic [XW-1:0]        d5_reg;
    side_t                sd5_reg, sd5_next;

    // Stage 6
    logic          v6_reg;
    logic [NW-1:0] nx_reg, ny_reg;
    logic [RW-1:0] den_reg;
    side_t         sd6_reg;

    // Divider alignment
    logic  dv_reg [DL];
    side_t dsd_reg [DL];
    logic [QW-1:0] qx, qy;

    // Final sum
    logic                 vf_reg;
    logic signed [SW-1:0] sx_reg, sy_reg;
    side_t                sdf_reg;

    logic                 out_valid_reg;
    logic                 hit_reg;
    how_t                 how_reg;
    logic signed [CW-1:0] px_reg, py_reg;

    localparam int EW = TW + XW + 2;
    logic signed [EW-1:0] c1s, c2s, lo_b, hi_b;
    logic                 par4, rng5;
    logic [XW-1:0]        tol_sh;

    assign tol_sh = XW'(tolerance) << PSH;
    assign par4   = (d3_reg == '0) || (d3_reg < tol_sh);

    assign c1s  = EW'(c14_reg) <<< TW;
    assign c2s  = EW'(c24_reg) <<< TW;
    assign lo_b = -$signed({2'b00, td_reg});
    assign hi_b = $signed({2'b00, d4_reg, {TW{1'b0}}}) + $signed({2'b00, td_reg});
    assign rng5 = (c1s >= lo_b) && (c1s <= hi_b) && (c2s >= lo_b) && (c2s <= hi_b);

    always_comb begin
        sd4_next        = sd3_reg;
        sd4_next.par    = par4;
        sd5_next        = sd4_reg;
        sd5_next.in_rng = rng5;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0; v6_reg <= 1'b0;
            vf_reg <= 1'b0; out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid; v2_reg <= v1_reg; v3_reg <= v2_reg;
            v4_reg <= v3_reg; v5_reg <= v4_reg; v6_reg <= v5_reg;
            vf_reg <= dv_reg[DL-1]; out_valid_reg <= vf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DL; i++) dv_reg[i] <= 1'b0;
        end else if (adv) begin
            dv_reg[0] <= v6_reg;
            for (int i = 1; i < DL; i++) dv_reg[i] <= dv_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dsd_reg[0] <= sd6_reg;
            for (int i = 1; i < DL; i++) dsd_reg[i] <= dsd_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1
            pd1_reg  <= in_item.v1x * in_item.v2y;
            pd2_reg  <= in_item.v1y * in_item.v2x;
            pc1a_reg <= in_item.v3x * in_item.v2y;
            pc1b_reg <= in_item.v3y * in_item.v2x;
            pc2a_reg <= in_item.v3x * in_item.v1y;
            pc2b_reg <= in_item.v3y * in_item.v1x;
            vx1_reg  <= in_item.v1x;
            vy1_reg  <= in_item.v1y;
            sd1_reg  <= '{shared: in_item.shared, par: 1'b0, in_rng: 1'b0,
                          sh_px: in_item.sh_px, sh_py: in_item.sh_py,
                          asx: in_item.asx, asy: in_item.asy};
            // stage 2
            d2s_reg <= XW'(pd1_reg) - XW'(pd2_reg);
            c12_reg <= XW'(pc1a_reg) - XW'(pc1b_reg);
            c22_reg <= XW'(pc2a_reg) - XW'(pc2b_reg);
            vx2_reg <= vx1_reg;
            vy2_reg <= vy1_reg;
            sd2_reg <= sd1_reg;
            // stage 3: flip signs so that the denominator is positive
            if (d2s_reg < 0) begin
                d3_reg  <= XW'(-d2s_reg);
                c13_reg <= -c12_reg;
                c23_reg <= -c22_reg;
            end else begin
                d3_reg  <= XW'(d2s_reg);
                c13_reg <= c12_reg;
                c23_reg <= c22_reg;
            end
            vx3_reg <= vx2_reg;
            vy3_reg <= vy2_reg;
            sd3_reg <= sd2_reg;
            // stage 4: tolerance scaling, parallel test, split point products
            td_reg  <= tolerance * d3_reg;
            d4_reg  <= d3_reg;
            c14_reg <= c13_reg;
            c24_reg <= c23_reg;
            pxl_reg <= vx3_reg * $signed({1'b0, c13_reg[LSW-1:0]});
            pyl_reg <= vy3_reg * $signed({1'b0, c13_reg[LSW-1:0]});
            pxh_reg <= vx3_reg * $signed(c13_reg[XW-1:LSW]);
            pyh_reg <= vy3_reg * $signed(c13_reg[XW-1:LSW]);
            sd4_reg <= sd4_next;
            // stage 5: range test, combine partial products
            px5_reg <= (PW'(pxh_reg) <<< LSW) + PW'(pxl_reg);
            py5_reg <= (PW'(pyh_reg) <<< LSW) + PW'(pyl_reg);
            d5_reg  <= d4_reg;
            sd5_reg <= sd5_next;
            // stage 6: biased dividend 2*v*c1 + d + 2^KSH * 2d
            nx_reg  <= (NW'(px5_reg) <<< 1) + NW'(d5_reg) + (NW'(d5_reg) << (KSH + 1));
            ny_reg  <= (NW'(py5_reg) <<< 1) + NW'(d5_reg) + (NW'(d5_reg) << (KSH + 1));
            den_reg <= {d5_reg, 1'b0};
            sd6_reg <= sd5_reg;
            // final sum: start + quotient - bias
            sx_reg  <= SW'(dsd_reg[DL-1].asx) + $signed({2'b00, qx})
                       - $signed(SW'(1) << KSH);
            sy_reg  <= SW'(dsd_reg[DL-1].asy) + $signed({2'b00, qy})
                       - $signed(SW'(1) << KSH);
            sdf_reg <= dsd_reg[DL-1];
        end
    end

    spi_div u_div_x (.aclk(aclk), .en(adv), .num(nx_reg), .den(den_reg), .quot(qx));
    spi_div u_div_y (.aclk(aclk), .en(adv), .num(ny_reg), .den(den_reg), .quot(qy));

    function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] mx, mn;
        mx = SW'({1'b0, {(CW-1){1'b1}}});
        mn = -mx - SW'(1);
        if (v > mx)      sat = {1'b0, {(CW-1){1'b1}}};
        else if (v < mn) sat = {1'b1, {(CW-1){1'b0}}};
        else             sat = v[CW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            priority if (sdf_reg.shared) begin
                hit_reg <= 1'b1; how_reg <= HOW_SHARED;
                px_reg  <= sdf_reg.sh_px; py_reg <= sdf_reg.sh_py;
            end else if (sdf_reg.par) begin
                hit_reg <= 1'b0; how_reg <= HOW_PARALLEL;
                px_reg  <= '0; py_reg <= '0;
            end else if (!sdf_reg.in_rng) begin
                hit_reg <= 1'b0; how_reg <= HOW_NONE;
                px_reg  <= '0; py_reg <= '0;
            end else begin
                hit_reg <= 1'b1; how_reg <= HOW_CROSS;
                px_reg  <= sat(sx_reg); py_reg <= sat(sy_reg);
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_hit   = hit_reg;
    assign m_how   = how_reg;
    assign m_px    = px_reg;
    assign m_py    = py_reg;

endmodule

// ===== hw/rtl/segment_pair_intersection_core.sv =====
// Segment pair intersection core: top level with the tolerance register.
// Depends on spi_pkg, spi_front, spi_fifo, spi_back and spi_div.
//
// Each request on the s_ channel carries two segments as signed Q16.16
// endpoints. Exactly one result leaves on the m_ channel for each request,
// in request order: a hit flag, how the answer was found (none, shared
// endpoint, proper crossing or parallel) and the meeting point.
// Both channels use valid/ready; a request or result moves when both are high.
// The front end classifies shared endpoints and forms the direction vectors;
// a four-entry queue sits between it and the arithmetic back end.
// The back end is a fixed pipeline: six stages of products and tests, a
// 38-register restoring divider (an input register and 37 stages of one
// quotient bit each), a sum stage and the result register. The back end takes
// one request every cycle while the receiver is not stalling.
// When the receiver stalls, the whole back end holds; the queue keeps taking
// requests until its four entries are full, and only then drops s_ready.
// Reset (aresetn low, synchronous) empties the queue and the pipeline and
// sets the tolerance to 66. The tolerance is written over the APB port at
// byte address 0 and should only be changed while the core is idle.
module segment_pair_intersection_core import spi_pkg::*; #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [CW-1:0] s_a_start_x,
    input  logic signed [CW-1:0] s_a_start_y,
    input  logic signed [CW-1:0] s_a_end_x,
    input  logic signed [CW-1:0] s_a_end_y,
    input  logic signed [CW-1:0] s_b_start_x,
    input  logic signed [CW-1:0] s_b_start_y,
    input  logic signed [CW-1:0] s_b_end_x,
    input  logic signed [CW-1:0] s_b_end_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic [1:0]           m_how_found,
    output logic signed [CW-1:0] m_point_x,
    output logic signed [CW-1:0] m_point_y
);

    // Tolerance register. paddr[2] selects the register index; the lower
    // bits address bytes within the word.
    logic [TW-1:0] tol_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOLERANCE)) begin
            tol_reg <= pwdata[TW-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TOLERANCE) ? {{(32-TW){1'b0}}, tol_reg} : 32'd0;

    // Front end and queue.
    item_t front_item, q_item;
    logic  q_valid, q_ready;

    spi_front u_front (
        .a_start_x(s_a_start_x), .a_start_y(s_a_start_y),
        .a_end_x(s_a_end_x),     .a_end_y(s_a_end_y),
        .b_start_x(s_b_start_x), .b_start_y(s_b_start_y),
        .b_end_x(s_b_end_x),     .b_end_y(s_b_end_y),
        .item(front_item)
    );

    spi_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(s_valid), .wr_ready(s_ready), .wr_item(front_item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
    );

    // Arithmetic back end.
    how_t how;

    spi_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .tolerance(tol_reg),
        .in_valid(q_valid), .in_item(q_item), .in_ready(q_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit(m_hit), .m_how(how), .m_px(m_point_x), .m_py(m_point_y)
    );

    assign m_how_found = how;

    // A hit is only ever reported for a shared endpoint or a proper crossing.
    a_hit_how: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> (m_how_found == HOW_SHARED || m_how_found == HOW_CROSS))
        else $error("hit reported with a non-meeting classification");

    // A miss always carries a zero point.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_point_x == '0 && m_point_y == '0))
        else $error("miss reported with a non-zero point");

    // Nothing is presented in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

endmodule
